[hdl/brb_pkg.sv]
package brb_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int CAP_RESET       = 4096;

    localparam int MODE_W   = 3;
    localparam int LEN_W    = 13;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int CNT_W    = 12;
    localparam int CAP_W    = 13;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH      = 3'd0,
        MODE_POP       = 3'd1,
        MODE_PEEK      = 3'd2,
        MODE_ADV_TAIL  = 3'd3,
        MODE_ADV_HEAD  = 3'd4,
        MODE_FREE_SPAN = 3'd5,
        MODE_DATA_SPAN = 3'd6,
        MODE_CLEAR     = 3'd7
    } mode_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

endpackage

[hdl/brb_store.sv]
module brb_store
    import brb_pkg::*;
#(
    parameter int DEPTH  = STORE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(STORE_DEPTH_DEF)
) (
    input  logic              aclk,
    input  mem_cmd_t          cmd,
    input  logic [ADDR_W-1:0] addr,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[addr] <= wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/byte_ring_buffer.sv]
// Byte ring buffer over a single-port byte store of STORE_DEPTH entries, with
// capacity slots in use and one slot always kept empty. One word is accepted
// per clock unless the output stalls; its result passes the input register,
// the pointer update with the store access, the result stage with the store's
// registered read, and the output register. Push, pop and peek runs carry
// one byte per word and are checked as a whole on their first word; head and
// tail move on the last word. A capacity write clears head, tail and any open
// run and must only be issued while the buffer is idle. The store needs no
// clearing after reset: bytes never written read as unknown values.
module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // mode [2:0], length [15:3], data_byte [23:16]
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // ok [0], read_byte [8:1], span_start [20:9], span_length [33:21],
    // data_count [45:34], free_count [57:46], zero [63:58]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic [CAP_W-1:0]    cfg_data,
    input  logic                cfg_valid,
    output logic                cfg_ready
);

    localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW       = (ADDR_W + 2 > 15) ? ADDR_W + 2 : 15;
    localparam int CAP_INIT = (CAP_RESET > STORE_DEPTH) ? STORE_DEPTH : CAP_RESET;

    logic [CW-1:0]     cap_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic              racc_reg, racc_next;

    logic              in_valid_reg;
    mode_t             in_mode_reg;
    logic [LEN_W-1:0]  in_len_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              s1_valid_reg;
    logic              s1_ok_reg, ok_next;
    logic              s1_rd_reg, rd_next;
    logic [POS_W-1:0]  s1_sstart_reg, sstart_next;
    logic [LEN_W-1:0]  s1_slen_reg, slen_next;
    logic [CNT_W-1:0]  s1_dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]  s1_fcnt_reg, fcnt_next;

    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic              en, proc, s_take, cfg_take;
    mem_cmd_t          mem_cmd;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_rdata;
    logic [BYTE_W-1:0] rbyte;

    logic [CW-1:0] cap, head_w, tail_w, len_w, off_w, t, used, used_next;
    logic [CW-1:0] tail_sum, tail_adv, head_sum, head_adv;
    logic [CW-1:0] a_sum, a_wrap, free_avail, avail, pos, n;
    logic [CW-1:0] cfg_w, cap_cfg;
    logic          fits_p, fits_q, last, acc;

    assign en        = !m_valid_reg || m_tready;
    assign proc      = en && in_valid_reg;
    assign s_tready  = en || !in_valid_reg;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    // effective capacity
    always_comb begin
        cfg_w = CW'(cfg_data);
        if (cfg_w == '0) begin
            cap_cfg = CW'(1);
        end else if (cfg_w > CW'(STORE_DEPTH)) begin
            cap_cfg = CW'(STORE_DEPTH);
        end else begin
            cap_cfg = cfg_w;
        end
    end

    always_comb begin
        cap    = cap_reg;
        head_w = CW'(head_reg);
        tail_w = CW'(tail_reg);
        len_w  = CW'(in_len_reg);
        off_w  = CW'(off_reg);

        t      = tail_w + cap - head_w;
        used   = (t >= cap) ? t - cap : t;
        fits_p = (len_w + used + CW'(1)) <= cap;
        fits_q = len_w <= used;

        tail_sum = tail_w + len_w;
        tail_adv = (tail_sum >= cap) ? tail_sum - cap : tail_sum;
        head_sum = head_w + len_w;
        head_adv = (head_sum >= cap) ? head_sum - cap : head_sum;

        a_sum  = ((in_mode_reg == MODE_PUSH) ? tail_w : head_w) + off_w;
        a_wrap = (a_sum >= cap) ? a_sum - cap : a_sum;
        last   = (off_w + CW'(1)) >= len_w;
        acc    = (off_reg == '0)
                 ? ((in_mode_reg == MODE_PUSH) ? fits_p : fits_q) : racc_reg;

        free_avail = cap - used - CW'(1);
        avail = (in_mode_reg == MODE_FREE_SPAN) ? free_avail : used;
        pos   = (in_mode_reg == MODE_FREE_SPAN) ? tail_w : head_w;
        n     = (len_w != '0 && len_w < avail) ? len_w : avail;
        if (pos + n >= cap) begin
            n = cap - pos;
        end

        head_next   = head_reg;
        tail_next   = tail_reg;
        off_next    = '0;
        racc_next   = 1'b0;
        used_next   = used;
        ok_next     = 1'b0;
        rd_next     = 1'b0;
        sstart_next = '0;
        slen_next   = '0;
        mem_cmd     = '0;
        mem_addr    = a_wrap[ADDR_W-1:0];

        case (in_mode_reg)
            MODE_PUSH, MODE_POP, MODE_PEEK: begin
                if (len_w == '0) begin
                    ok_next = 1'b1;
                end else if (len_w < CW'(STORE_DEPTH)) begin
                    ok_next = acc;
                    if (acc) begin
                        mem_cmd.wr = (in_mode_reg == MODE_PUSH);
                        mem_cmd.rd = (in_mode_reg != MODE_PUSH);
                        rd_next    = (in_mode_reg != MODE_PUSH);
                    end
                    if (last) begin
                        if (acc) begin
                            if (in_mode_reg == MODE_PUSH) begin
                                if (fits_p) begin
                                    tail_next = tail_adv[ADDR_W-1:0];
                                    used_next = used + len_w;
                                end else begin
                                    ok_next = 1'b0;
                                end
                            end else if (fits_q) begin
                                if (in_mode_reg == MODE_POP) begin
                                    head_next = head_adv[ADDR_W-1:0];
                                    used_next = used - len_w;
                                end
                            end else begin
                                ok_next = 1'b0;
                            end
                        end
                    end else begin
                        off_next  = off_reg + ADDR_W'(1);
                        racc_next = acc;
                    end
                end
            end
            MODE_ADV_TAIL: begin
                if (fits_p) begin
                    tail_next = tail_adv[ADDR_W-1:0];
                    used_next = used + len_w;
                    ok_next   = 1'b1;
                end
            end
            MODE_ADV_HEAD: begin
                if (fits_q) begin
                    head_next = head_adv[ADDR_W-1:0];
                    used_next = used - len_w;
                    ok_next   = 1'b1;
                end
            end
            MODE_FREE_SPAN, MODE_DATA_SPAN: begin
                sstart_next = pos[POS_W-1:0];
                slen_next   = n[LEN_W-1:0];
                ok_next     = 1'b1;
            end
            MODE_CLEAR: begin
                head_next = '0;
                tail_next = '0;
                used_next = '0;
                ok_next   = 1'b1;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase

        dcnt_next = used_next[CNT_W-1:0];
        fcnt_next = CNT_W'(cap - used_next - CW'(1));

        if (!proc) begin
            mem_cmd = '0;
        end
    end

    // ring state and capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CW'(CAP_INIT);
            head_reg <= '0;
            tail_reg <= '0;
            off_reg  <= '0;
            racc_reg <= 1'b0;
        end else if (cfg_take) begin
            cap_reg  <= cap_cfg;
            head_reg <= '0;
            tail_reg <= '0;
            off_reg  <= '0;
            racc_reg <= 1'b0;
        end else if (proc) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            off_reg  <= off_next;
            racc_reg <= racc_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_mode_reg <= mode_t'(s_tdata[MODE_W-1:0]);
            in_len_reg  <= s_tdata[MODE_W +: LEN_W];
            in_byte_reg <= s_tdata[MODE_W+LEN_W +: BYTE_W];
        end
    end

    // result stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid_reg;
            m_valid_reg  <= s1_valid_reg;
        end
    end

    assign rbyte = s1_rd_reg ? mem_rdata : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ok_reg     <= ok_next;
            s1_rd_reg     <= rd_next;
            s1_sstart_reg <= sstart_next;
            s1_slen_reg   <= slen_next;
            s1_dcnt_reg   <= dcnt_next;
            s1_fcnt_reg   <= fcnt_next;
            m_data_reg    <= M_DATA_W'({s1_fcnt_reg, s1_dcnt_reg, s1_slen_reg,
                                        s1_sstart_reg, rbyte, s1_ok_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    brb_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (in_byte_reg),
        .rdata (mem_rdata)
    );

endmodule

[hdl/brb_checker.sv]
module brb_checker
    import brb_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [2:0] inflight_reg, inflight_next;
    logic       s_take, m_take;

    assign s_take = s_tvalid && s_tready;
    assign m_take = m_tvalid && m_tready;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_take && !m_take) begin
            inflight_next = inflight_reg + 3'd1;
        end else if (!s_take && m_take) begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // no word out after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // every result word has an accepted word behind it, at most three in flight
    a_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid |-> inflight_reg != 3'd0) and (inflight_reg <= 3'd3))
        else $error("result word count does not match accepted words");

    // a span result is always accepted and carries no byte
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:21] != 13'd0 |-> m_tdata[0] && m_tdata[8:1] == 8'd0)
        else $error("span word with refused status or read byte");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
